FILE: hdl/tppfa_pkg.sv
// Package: widths, codes and constants of the two-pool page frame allocator.
`timescale 1ns / 1ps
package tppfa_pkg;

	localparam int ADDR_BITS         = 34;
	localparam int PAGE_STACK_DEPTH  = 32768;
	localparam int SUPER_STACK_DEPTH = 16;

	localparam int PAGE_SHIFT  = 12;
	localparam int SUPER_SHIFT = 21;
	localparam longint PAGE_BYTES  = 64'd1 << PAGE_SHIFT;
	localparam longint SUPER_BYTES = 2 * 1024 * 1024;

	localparam int PFN_W = ADDR_BITS - PAGE_SHIFT;
	localparam int SFN_W = ADDR_BITS - SUPER_SHIFT;

	localparam int PSTK_CNT_W = $clog2(PAGE_STACK_DEPTH + 1);
	localparam int PSTK_IDX_W = $clog2(PAGE_STACK_DEPTH);
	localparam int SSTK_CNT_W = $clog2(SUPER_STACK_DEPTH + 1);
	localparam int SSTK_IDX_W = (SUPER_STACK_DEPTH > 1) ? $clog2(SUPER_STACK_DEPTH) : 1;

	localparam int MODE_W   = 3;
	localparam int STATUS_W = 2;
	localparam int RSV_W    = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = ADDR_BITS;

	localparam logic [ADDR_BITS-1:0] KERNEL_END_RST  = ADDR_BITS'(64'd2147483648);
	localparam logic [ADDR_BITS-1:0] PHYS_TOP_RST    = ADDR_BITS'(64'd2281701376);
	localparam logic [RSV_W-1:0]     SUPER_RESERVE_RST = RSV_W'(10);

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC_PAGE  = 3'd0,
		MODE_FREE_PAGE   = 3'd1,
		MODE_ALLOC_SUPER = 3'd2,
		MODE_FREE_SUPER  = 3'd3,
		MODE_INIT        = 3'd4
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_BAD   = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KERNEL_END    = 2'd0,
		CFG_PHYS_TOP      = 2'd1,
		CFG_SUPER_RESERVE = 2'd2
	} cfg_idx_t;

endpackage

FILE: hdl/tppfa_req_if.sv
// Interface: request channel carrying mode and physical address.
`timescale 1ns / 1ps
interface tppfa_req_if import tppfa_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [MODE_W-1:0]     mode;
	logic [ADDR_BITS-1:0]  phys_addr;

	modport source (output valid, output mode, output phys_addr, input ready);
	modport sink (input valid, input mode, input phys_addr, output ready);
endinterface

FILE: hdl/tppfa_rsp_if.sv
// Interface: result channel carrying allocated address and status.
`timescale 1ns / 1ps
interface tppfa_rsp_if import tppfa_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [ADDR_BITS-1:0]  alloc_addr;
	logic [STATUS_W-1:0]   status;

	modport source (output valid, output alloc_addr, output status, input ready);
	modport sink (input valid, input alloc_addr, input status, output ready);
endinterface

FILE: hdl/two_pool_page_frame_allocator_unit.sv
// Top level: two-pool LIFO page and superpage frame allocator.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+------------------------------------
//  req     | in  | valid/ready  | mode[2:0], phys_addr[33:0]
//  rsp     | out | valid/ready  | alloc_addr[33:0], status[1:0]
//  cfg     | in  | cfg_we       | cfg_index[1:0], cfg_data[33:0]
//
// One item per cycle while results are taken; an item passes the input register, then the result register.
// The page stack lives in a RAM with one write and one read port; its top is
// kept in a register and the entry below it is prefetched every cycle, so pops
// run back to back.
// Reset clears counts and fresh runs; both pools are empty until an init or free item.
// A stalled result holds the input register; a new item is still taken
// while the result waits, as long as the input register is empty.
`timescale 1ns / 1ps
module two_pool_page_frame_allocator_unit import tppfa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	tppfa_req_if.sink              req,
	tppfa_rsp_if.source            rsp,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [ADDR_BITS-1:0] kend_q;
	logic [ADDR_BITS-1:0] top_q;
	logic [RSV_W-1:0]     rsv_q;

	logic                 v_s1;
	logic [MODE_W-1:0]    mode_s1;
	logic [ADDR_BITS-1:0] pa_s1;

	logic                 rsp_valid_q;
	logic [ADDR_BITS-1:0] rsp_addr_q;
	logic [STATUS_W-1:0]  rsp_status_q;

	logic [PSTK_CNT_W-1:0] pcnt_q, pcnt_d;
	logic [PFN_W-1:0]      ptop_q, ptop_d;
	logic [PFN_W-1:0]      pnext_q, pnext_d;
	logic [PFN_W-1:0]      pfloor_q, pfloor_d;
	logic [PFN_W-1:0]      page_mem [PAGE_STACK_DEPTH];
	logic [PFN_W-1:0]      prd_q;
	logic [PSTK_IDX_W-1:0] prd_addr;
	logic                  pwr_en;

	logic [SSTK_CNT_W-1:0] scnt_q, scnt_d;
	logic [SFN_W-1:0]      snext_q, snext_d;
	logic [SFN_W-1:0]      sfloor_q, sfloor_d;
	logic [SFN_W-1:0]      sstk_q [SUPER_STACK_DEPTH];
	logic [SSTK_IDX_W-1:0] stop_idx;
	logic                  swr_en;

	logic                 adv;
	logic                 fire;
	logic [ADDR_BITS-1:0] addr_d;
	status_t              status_d;

	logic [ADDR_BITS-1:0] reserve;
	logic [ADDR_BITS-1:0] split_raw;
	logic [ADDR_BITS-1:0] split;
	logic [ADDR_BITS:0]   kend_up;
	logic [ADDR_BITS:0]   split_up;
	logic [PFN_W:0]       plo;
	logic [PFN_W-1:0]     phi;
	logic [SFN_W:0]       slo;
	logic [SFN_W-1:0]     shi;
	logic                 pbad;
	logic                 sbad;

	assign adv       = !rsp_valid_q || rsp.ready;
	assign fire      = v_s1 && adv;
	assign req.ready = !v_s1 || adv;

	assign rsp.valid      = rsp_valid_q;
	assign rsp.alloc_addr = rsp_addr_q;
	assign rsp.status     = rsp_status_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kend_q <= KERNEL_END_RST;
			top_q  <= PHYS_TOP_RST;
			rsv_q  <= SUPER_RESERVE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KERNEL_END:    kend_q <= cfg_data[ADDR_BITS-1:0];
				CFG_PHYS_TOP:      top_q  <= cfg_data[ADDR_BITS-1:0];
				CFG_SUPER_RESERVE: rsv_q  <= cfg_data[RSV_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_s1 <= req.mode;
			pa_s1   <= req.phys_addr;
		end
	end

	// pool split for init
	always_comb begin
		reserve   = ADDR_BITS'(rsv_q) << SUPER_SHIFT;
		split_raw = (top_q >= reserve) ? (top_q - reserve) : '0;
		split     = split_raw;
		if (split_raw[SUPER_SHIFT-1:0] != '0) begin
			split[PAGE_SHIFT-1:0] = '0;
		end
		kend_up  = {1'b0, kend_q} + (ADDR_BITS+1)'(PAGE_BYTES - 1);
		plo      = kend_up[ADDR_BITS:PAGE_SHIFT];
		phi      = split[ADDR_BITS-1:PAGE_SHIFT];
		split_up = {1'b0, split} + (ADDR_BITS+1)'(SUPER_BYTES - 1);
		slo      = split_up[ADDR_BITS:SUPER_SHIFT];
		shi      = top_q[ADDR_BITS-1:SUPER_SHIFT];
	end

	assign pbad = (pa_s1[PAGE_SHIFT-1:0] != '0) || (pa_s1 < kend_q) || (pa_s1 >= top_q);
	assign sbad = (pa_s1[SUPER_SHIFT-1:0] != '0) || (pa_s1 >= top_q);
	assign stop_idx = SSTK_IDX_W'(scnt_q - SSTK_CNT_W'(1));

	// request execution
	always_comb begin
		addr_d   = '0;
		status_d = ST_OK;
		pcnt_d   = pcnt_q;
		ptop_d   = ptop_q;
		pnext_d  = pnext_q;
		pfloor_d = pfloor_q;
		scnt_d   = scnt_q;
		snext_d  = snext_q;
		sfloor_d = sfloor_q;
		pwr_en   = 1'b0;
		swr_en   = 1'b0;
		if (fire) begin
			case (mode_s1)
				MODE_ALLOC_PAGE: begin
					if (pcnt_q != '0) begin
						pcnt_d = pcnt_q - PSTK_CNT_W'(1);
						ptop_d = prd_q;
						addr_d = {ptop_q, {PAGE_SHIFT{1'b0}}};
					end else if (pnext_q > pfloor_q) begin
						pnext_d = pnext_q - PFN_W'(1);
						addr_d  = {pnext_d, {PAGE_SHIFT{1'b0}}};
					end else begin
						status_d = ST_EMPTY;
					end
				end
				MODE_FREE_PAGE: begin
					if (pbad) begin
						status_d = ST_BAD;
					end else if (pcnt_q >= PSTK_CNT_W'(PAGE_STACK_DEPTH)) begin
						status_d = ST_FULL;
					end else begin
						pwr_en = 1'b1;
						pcnt_d = pcnt_q + PSTK_CNT_W'(1);
						ptop_d = pa_s1[ADDR_BITS-1:PAGE_SHIFT];
					end
				end
				MODE_ALLOC_SUPER: begin
					if (scnt_q != '0) begin
						scnt_d = scnt_q - SSTK_CNT_W'(1);
						addr_d = {sstk_q[stop_idx], {SUPER_SHIFT{1'b0}}};
					end else if (snext_q > sfloor_q) begin
						snext_d = snext_q - SFN_W'(1);
						addr_d  = {snext_d, {SUPER_SHIFT{1'b0}}};
					end else begin
						status_d = ST_EMPTY;
					end
				end
				MODE_FREE_SUPER: begin
					if (sbad) begin
						status_d = ST_BAD;
					end else if (scnt_q >= SSTK_CNT_W'(SUPER_STACK_DEPTH)) begin
						status_d = ST_FULL;
					end else begin
						swr_en = 1'b1;
						scnt_d = scnt_q + SSTK_CNT_W'(1);
					end
				end
				MODE_INIT: begin
					pcnt_d   = '0;
					scnt_d   = '0;
					pfloor_d = plo[PFN_W-1:0];
					pnext_d  = ({1'b0, phi} > plo) ? phi : plo[PFN_W-1:0];
					sfloor_d = slo[SFN_W-1:0];
					snext_d  = ({1'b0, shi} > slo) ? shi : slo[SFN_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// prefetch the entry below the top of the page stack
	assign prd_addr = PSTK_IDX_W'(pcnt_d - PSTK_CNT_W'(2));

	always_ff @(posedge clk) begin
		if (pwr_en) begin
			page_mem[pcnt_q[PSTK_IDX_W-1:0]] <= pa_s1[ADDR_BITS-1:PAGE_SHIFT];
		end
		prd_q <= page_mem[prd_addr];
	end

	always_ff @(posedge clk) begin
		if (swr_en) begin
			sstk_q[scnt_q[SSTK_IDX_W-1:0]] <= pa_s1[ADDR_BITS-1:SUPER_SHIFT];
		end
		ptop_q <= ptop_d;
	end

	// pool state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q   <= '0;
			pnext_q  <= '0;
			pfloor_q <= '0;
			scnt_q   <= '0;
			snext_q  <= '0;
			sfloor_q <= '0;
		end else begin
			pcnt_q   <= pcnt_d;
			pnext_q  <= pnext_d;
			pfloor_q <= pfloor_d;
			scnt_q   <= scnt_d;
			snext_q  <= snext_d;
			sfloor_q <= sfloor_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_addr_q   <= addr_d;
			rsp_status_q <= status_d;
		end
	end

`ifndef SYNTHESIS
	a_pcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q <= PSTK_CNT_W'(PAGE_STACK_DEPTH))
		else $error("page stack count beyond depth");

	a_scnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		scnt_q <= SSTK_CNT_W'(SUPER_STACK_DEPTH))
		else $error("superpage stack count beyond depth");

	a_pfresh_order: assert property (@(posedge clk) disable iff (!arst_n)
		pnext_q >= pfloor_q)
		else $error("page fresh run inverted");

	a_sfresh_order: assert property (@(posedge clk) disable iff (!arst_n)
		snext_q >= sfloor_q)
		else $error("superpage fresh run inverted");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (rsp_status_q != ST_OK) |-> rsp_addr_q == '0)
		else $error("failed item carries an address");
`endif

endmodule
